// ----- hw/rtl/adsr_pkg.sv -----
package adsr_pkg;

  localparam int MS_WIDTH        = 14;
  localparam int LEVEL_WIDTH     = 16;
  localparam int RATE_WIDTH      = 18;
  localparam int CFG_WIDTH       = 18;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int OPCODE_WIDTH    = 2;
  // ms * rate fits here; also the widest span in samples times 1000
  localparam int SPAN_WIDTH      = MS_WIDTH + RATE_WIDTH;
  localparam int NUM_WIDTH       = SPAN_WIDTH + LEVEL_WIDTH;
  localparam int UNITY_SHIFT     = 15;
  localparam int MS_PER_SEC      = 1000;
  localparam int RELEASE_EARLY   = 2;

  localparam logic [MS_WIDTH-1:0]    ATTACK_MS_RST  = 14'd300;
  localparam logic [MS_WIDTH-1:0]    DECAY_MS_RST   = 14'd100;
  localparam logic [MS_WIDTH-1:0]    RELEASE_MS_RST = 14'd100;
  localparam logic [LEVEL_WIDTH-1:0] SUSTAIN_RST    = 16'd22938;
  localparam logic [RATE_WIDTH-1:0]  RATE_RST       = 18'd48000;

  typedef enum logic [OPCODE_WIDTH-1:0] {
    OP_SAMPLE   = 2'd0,
    OP_KEY_DOWN = 2'd1,
    OP_KEY_UP   = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ATTACK_MS  = 3'd0,
    REG_DECAY_MS   = 3'd1,
    REG_RELEASE_MS = 3'd2,
    REG_SUSTAIN    = 3'd3,
    REG_RATE_HZ    = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    ENV_STANDBY = 3'd0,
    ENV_ATTACK  = 3'd1,
    ENV_DECAY   = 3'd2,
    ENV_SUSTAIN = 3'd3,
    ENV_RELEASE = 3'd4
  } env_phase_t;

  typedef enum logic [1:0] {
    RES_SCALED = 2'd0,
    RES_PASS   = 2'd1,
    RES_ZERO   = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     key_down;
    logic     key_up;
    logic     evaluate;
    logic     advance;
    logic     count_up;
    logic     set_res;
    res_sel_t res_sel;
    logic     form_num;
    logic     mul_step;
    logic     div_step;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    opcode_t    opcode;
    env_phase_t env_phase;
    logic       span_done;
    logic       count_zero;
    logic       out_busy;
  } status_t;

endpackage

// ----- hw/rtl/adsr_in_if.sv -----
interface adsr_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  import adsr_pkg::*;

  logic                           valid;
  logic                           ready;
  logic [OPCODE_WIDTH-1:0]        opcode;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output opcode, output sample_in, input ready);
  modport sink   (input valid, input opcode, input sample_in, output ready);
endinterface

// ----- hw/rtl/adsr_out_if.sv -----
interface adsr_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- hw/rtl/adsr_envelope_gain.sv -----
// Channel    Dir  Payload                      Meaning
// audio_in   in   opcode[1:0], sample_in[SW]   sample / key down / key up item
// audio_out  out  sample_out[SW]               one enveloped sample per sample item
// cfg        in   cfg_we, cfg_index, cfg_data  register writes, index 0..4
//
// Sample item in attack, decay, sustain or release: accept, evaluate the phase end,
// form the numerator, then the serial shift-add multiply and the restoring divide,
// one bit per cycle each, then emit. Phase-ending, standby and key items skip both.
// Reset (rst, synchronous): standby, counter zero, registers at their defaults.
// A new item is taken while a finished result still waits in the output register;
// the block only stalls in its final step if that register is still full.
module adsr_envelope_gain
  import adsr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  adsr_in_if.sink                    audio_in,
  adsr_out_if.source                 audio_out
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // Controller sequences one item: accept, evaluate phase end, form the
  // gain fraction, multiply by the magnitude, divide, then emit.
  adsr_ctrl #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (audio_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath holds config, envelope phase/counter, arithmetic and output register.
  adsr_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .opcode    (audio_in.opcode),
    .sample_in (audio_in.sample_in),
    .audio_out (audio_out),
    .cmd       (cmd),
    .status    (status)
  );

  // no item is taken while reset is held
  assign audio_in.ready = in_ready && !rst;

`ifndef ASSERT_OFF
  // nothing is emitted in the cycle right after an item is taken
  a_no_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    (audio_in.valid && audio_in.ready) |=> !$rose(audio_out.valid))
    else $error("result appeared right after accept");

  // a new result only comes out of a busy block
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(audio_out.valid) |-> !$past(audio_in.ready))
    else $error("result emitted while idle");

  // standby always has a cleared sample counter
  a_standby_count_zero: assert property (@(posedge clk) disable iff (rst)
    (status.env_phase == ENV_STANDBY) |-> status.count_zero)
    else $error("counter nonzero in standby");
`endif

endmodule

// ----- hw/rtl/adsr_ctrl.sv -----
module adsr_ctrl
  import adsr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int IW = $clog2(SAMPLE_WIDTH);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EVAL  = 6'b000010,
    ST_NUMER = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t          state, state_next;
  logic [IW-1:0]   iter, iter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd        = '0;
    cmd.res_sel = RES_SCALED;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.evaluate = 1'b1;
        unique case (status.opcode)
          OP_KEY_DOWN: begin
            cmd.key_down = 1'b1;
            state_next   = ST_IDLE;
          end
          OP_KEY_UP: begin
            cmd.key_up = 1'b1;
            state_next = ST_IDLE;
          end
          OP_SAMPLE: begin
            cmd.set_res = 1'b1;
            unique case (status.env_phase)
              ENV_SUSTAIN: begin
                cmd.res_sel = RES_SCALED;
                state_next  = ST_NUMER;
              end
              ENV_ATTACK, ENV_DECAY, ENV_RELEASE: begin
                if (status.span_done) begin
                  cmd.advance = 1'b1;
                  cmd.res_sel = (status.env_phase == ENV_RELEASE) ? RES_ZERO : RES_PASS;
                  state_next  = ST_DONE;
                end else begin
                  cmd.count_up = 1'b1;
                  cmd.res_sel  = RES_SCALED;
                  state_next   = ST_NUMER;
                end
              end
              default: begin
                cmd.res_sel = RES_ZERO;
                state_next  = ST_DONE;
              end
            endcase
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_NUMER: begin
        cmd.form_num = 1'b1;
        iter_next    = IW'(SAMPLE_WIDTH - 1);
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (iter == '0) begin
          iter_next  = IW'(SAMPLE_WIDTH - 1);
          state_next = ST_DIV;
        end else begin
          iter_next = iter - 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (iter == '0) begin
          state_next = ST_DONE;
        end else begin
          iter_next = iter - 1'b1;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/adsr_datapath.sv -----
module adsr_datapath
  import adsr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [CFG_WIDTH-1:0]           cfg_data,
  input  logic [OPCODE_WIDTH-1:0]        opcode,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  adsr_out_if.source                     audio_out,
  input  cmd_t                           cmd,
  output status_t                        status
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int KW = COUNT_WIDTH + 10;     // count * 1000
  localparam int PW = SAMPLE_WIDTH + NUM_WIDTH;

  // configuration
  logic [MS_WIDTH-1:0]    attack_ms, decay_ms, release_ms;
  logic [LEVEL_WIDTH-1:0] sustain_level;
  logic [RATE_WIDTH-1:0]  sample_rate_hz;

  // envelope state
  env_phase_t             env_phase;
  logic [COUNT_WIDTH-1:0] count;

  // per-item registers
  opcode_t                op_r;
  logic [SW-1:0]          raw_r;
  logic                   neg_r;
  logic [SW-1:0]          mag_sh;
  logic [SPAN_WIDTH-1:0]  nprod_r;
  logic [KW-1:0]          k_r;
  logic [SPAN_WIDTH-1:0]  n_r;
  logic [SPAN_WIDTH-1:0]  d_r;
  logic [NUM_WIDTH-1:0]   sk_r;
  logic [NUM_WIDTH-1:0]   num_r;
  logic [PW-1:0]          ds_r;
  logic [PW-1:0]          rem_r;
  logic [SW-1:0]          q_r;
  res_sel_t               res_sel_r;

  logic                   out_valid;
  logic [SW-1:0]          out_data;

  logic [MS_WIDTH-1:0]    ms_sel;
  logic [SW-1:0]          mag;
  logic [SPAN_WIDTH-1:0]  n_cur;
  logic                   span_done;
  logic [NUM_WIDTH-1:0]   num_cur;
  logic [NUM_WIDTH-1:0]   den_cur;
  logic [SW-1:0]          sat;
  logic [SW-1:0]          result;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ms      <= ATTACK_MS_RST;
      decay_ms       <= DECAY_MS_RST;
      release_ms     <= RELEASE_MS_RST;
      sustain_level  <= SUSTAIN_RST;
      sample_rate_hz <= RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK_MS:  attack_ms      <= cfg_data[MS_WIDTH-1:0];
        REG_DECAY_MS:   decay_ms       <= cfg_data[MS_WIDTH-1:0];
        REG_RELEASE_MS: release_ms     <= cfg_data[MS_WIDTH-1:0];
        REG_SUSTAIN:    sustain_level  <= cfg_data[LEVEL_WIDTH-1:0];
        REG_RATE_HZ:    sample_rate_hz <= cfg_data[RATE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (env_phase)
      ENV_ATTACK: ms_sel = attack_ms;
      ENV_DECAY:  ms_sel = decay_ms;
      default:    ms_sel = release_ms;
    endcase
  end

  assign mag = sample_in[SW-1] ? (~sample_in + 1'b1) : sample_in;

  // zero span counts as one sample
  assign n_cur = (nprod_r == '0) ? SPAN_WIDTH'(MS_PER_SEC) : nprod_r;

  always_comb begin
    if (env_phase == ENV_RELEASE) begin
      span_done = ((KW+1)'(k_r) + (KW+1)'(RELEASE_EARLY * MS_PER_SEC)) >= (KW+1)'(n_cur);
    end else begin
      span_done = (KW+1)'(k_r) >= (KW+1)'(n_cur);
    end
  end

  // envelope phase and sample counter
  always_ff @(posedge clk) begin
    if (rst) begin
      env_phase <= ENV_STANDBY;
      count     <= '0;
    end else begin
      priority if (cmd.key_down) begin
        env_phase <= ENV_ATTACK;
        count     <= '0;
      end else if (cmd.key_up) begin
        env_phase <= ENV_RELEASE;
        count     <= '0;
      end else if (cmd.advance) begin
        unique case (env_phase)
          ENV_ATTACK: env_phase <= ENV_DECAY;
          ENV_DECAY:  env_phase <= ENV_SUSTAIN;
          default:    env_phase <= ENV_STANDBY;
        endcase
        count <= '0;
      end else if (cmd.count_up) begin
        if (count != '1) begin
          count <= count + 1'b1;
        end
      end else begin
        count <= count;
      end
    end
  end

  // numerator and denominator of the gain
  always_comb begin
    unique case (env_phase)
      ENV_ATTACK: begin
        num_cur = NUM_WIDTH'(k_r[SPAN_WIDTH-1:0]);
        den_cur = NUM_WIDTH'(n_r);
      end
      ENV_DECAY: begin
        num_cur = (NUM_WIDTH'(d_r) << UNITY_SHIFT) + sk_r;
        den_cur = NUM_WIDTH'(n_r) << UNITY_SHIFT;
      end
      ENV_SUSTAIN: begin
        num_cur = NUM_WIDTH'(sustain_level);
        den_cur = NUM_WIDTH'(1) << UNITY_SHIFT;
      end
      ENV_RELEASE: begin
        num_cur = NUM_WIDTH'(sustain_level) * NUM_WIDTH'(d_r);
        den_cur = NUM_WIDTH'(n_r) << UNITY_SHIFT;
      end
      default: begin
        num_cur = '0;
        den_cur = '0;
      end
    endcase
  end

  // item datapath: load, span, numerator, shift-add multiply, restoring divide
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= opcode_t'(opcode);
      raw_r   <= sample_in;
      neg_r   <= sample_in[SW-1];
      mag_sh  <= mag;
      nprod_r <= SPAN_WIDTH'(ms_sel) * SPAN_WIDTH'(sample_rate_hz);
      k_r     <= KW'(count) * KW'(MS_PER_SEC);
    end
    if (cmd.evaluate) begin
      n_r  <= n_cur;
      d_r  <= n_cur - k_r[SPAN_WIDTH-1:0];
      sk_r <= NUM_WIDTH'(sustain_level) * NUM_WIDTH'(k_r[SPAN_WIDTH-1:0]);
    end
    if (cmd.set_res) begin
      res_sel_r <= cmd.res_sel;
    end
    if (cmd.form_num) begin
      num_r <= num_cur;
      ds_r  <= PW'(den_cur) << (SW - 1);
      rem_r <= '0;
      q_r   <= '0;
    end
    if (cmd.mul_step) begin
      rem_r  <= (rem_r << 1) + (mag_sh[SW-1] ? PW'(num_r) : PW'(0));
      mag_sh <= mag_sh << 1;
    end
    if (cmd.div_step) begin
      if (rem_r >= ds_r) begin
        rem_r <= rem_r - ds_r;
        q_r   <= {q_r[SW-2:0], 1'b1};
      end else begin
        q_r <= {q_r[SW-2:0], 1'b0};
      end
      ds_r <= ds_r >> 1;
    end
  end

  // saturate magnitude back to a signed sample
  always_comb begin
    if (!neg_r) begin
      sat = q_r[SW-1] ? {1'b0, {(SW-1){1'b1}}} : q_r;
    end else begin
      sat = q_r[SW-1] ? {1'b1, {(SW-1){1'b0}}} : (~q_r + 1'b1);
    end
  end

  always_comb begin
    unique case (res_sel_r)
      RES_SCALED: result = sat;
      RES_PASS:   result = raw_r;
      default:    result = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (audio_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= result;
    end
  end

  assign audio_out.valid      = out_valid;
  assign audio_out.sample_out = out_data;

  assign status.opcode     = op_r;
  assign status.env_phase  = env_phase;
  assign status.span_done  = span_done;
  assign status.count_zero = (count == '0);
  assign status.out_busy   = out_valid && !audio_out.ready;

endmodule

// ----- tb/adsr_envelope_gain_tb.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the ADSR gain stage.
// Items go in on audio_in, enveloped samples come out on audio_out. Every accepted
// input item is run through a local envelope model at the accepting edge; each
// sample item queues one expected output sample. The output monitor pops and
// compares in order. Register writes only happen with the block drained.
module adsr_envelope_gain_tb;
  import adsr_pkg::*;

  localparam int SW = 16;
  localparam int CW = 32;

  // drained-block settle time for trailing key items, which leave no result
  localparam int SETTLE_CYCLES = 8;
  // tail wait at the end, long enough for one full sample item plus margin
  localparam int END_CYCLES    = 48;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_REPORTS   = 30;

  localparam logic [127:0] POS_LIM = (128'd1 << (SW - 1)) - 128'd1;
  localparam logic [127:0] NEG_LIM = (128'd1 << (SW - 1));

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]       cfg_data;

  adsr_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
  adsr_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

  adsr_envelope_gain #(
    .SAMPLE_WIDTH(SW),
    .COUNT_WIDTH (CW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .audio_in (in_ch),
    .audio_out(out_ch)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Envelope model state and register copies
  // ---------------------------------------------------------------------------
  env_phase_t          gain_phase;
  logic [CW-1:0]       gain_count;
  logic [MS_WIDTH-1:0] atk_ms, dec_ms, rel_ms;
  logic [LEVEL_WIDTH-1:0] sus_level;
  logic [RATE_WIDTH-1:0]  rate_hz;

  logic [SW-1:0] env_out_q[$];   // expected output samples, oldest first

  int errors      = 0;
  int sent_items  = 0;           // opcode 3 items not counted
  int cycles      = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold     = 0;           // receiver hold-off, cycles left

  // ms * rate, i.e. 1000x the phase length in samples; zero means one sample
  function automatic logic [63:0] phase_span(logic [MS_WIDTH-1:0] ms);
    logic [63:0] n;
    n = 64'(ms) * 64'(rate_hz);
    return (n == 64'd0) ? 64'd1000 : n;
  endfunction

  // trunc(s * num / den), saturated to the sample range
  function automatic logic [SW-1:0] gain_apply(logic [SW-1:0] raw, logic [63:0] num,
                                              logic [63:0] den);
    logic [127:0]  mag;
    logic [127:0]  q;
    logic [SW-1:0] lo;
    mag = raw[SW-1] ? ((128'd1 << SW) - 128'(raw)) : 128'(raw);
    q   = (mag * 128'(num)) / 128'(den);
    if (!raw[SW-1]) begin
      if (q > POS_LIM) q = POS_LIM;
      return q[SW-1:0];
    end
    if (q > NEG_LIM) q = NEG_LIM;
    lo = q[SW-1:0];
    return ~lo + 1'b1;
  endfunction

  // one accepted item through the envelope; has_out set for sample items
  function automatic void apply_envelope(input opcode_t op, input logic [SW-1:0] raw,
                                         output bit has_out, output logic [SW-1:0] res);
    logic [63:0] n;
    logic [63:0] ck;
    logic [63:0] num;
    ck      = 64'(gain_count) * 64'd1000;
    has_out = 1'b0;
    res     = '0;
    case (op)
      OP_KEY_DOWN: begin
        gain_phase = ENV_ATTACK;
        gain_count = '0;
      end
      OP_KEY_UP: begin
        gain_phase = ENV_RELEASE;
        gain_count = '0;
      end
      OP_SAMPLE: begin
        has_out = 1'b1;
        case (gain_phase)
          ENV_ATTACK: begin
            n = phase_span(atk_ms);
            if (ck >= n) begin
              gain_phase = ENV_DECAY;
              gain_count = '0;
              res        = raw;
            end else begin
              res = gain_apply(raw, ck, n);
              if (gain_count != '1) gain_count++;
            end
          end
          ENV_DECAY: begin
            n = phase_span(dec_ms);
            if (ck >= n) begin
              gain_phase = ENV_SUSTAIN;
              gain_count = '0;
              res        = raw;
            end else begin
              num = 64'd32768 * (n - ck) + 64'(sus_level) * ck;
              res = gain_apply(raw, num, 64'd32768 * n);
              if (gain_count != '1) gain_count++;
            end
          end
          ENV_SUSTAIN: res = gain_apply(raw, 64'(sus_level), 64'd32768);
          ENV_RELEASE: begin
            n = phase_span(rel_ms);
            // release ends two samples early
            if (ck + 64'd2000 >= n) begin
              gain_phase = ENV_STANDBY;
              gain_count = '0;
              res        = '0;
            end else begin
              res = gain_apply(raw, 64'(sus_level) * (n - ck), 64'd32768 * n);
              if (gain_count != '1) gain_count++;
            end
          end
          default: res = '0;
        endcase
      end
      default: ;  // unused opcode: ignored
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one item from a falling edge and wait for the accepting rising edge.
  // valid stays high afterwards; a following call either reuses it or drops it
  // for an idle gap.
  task automatic send_item(input opcode_t op, input logic [SW-1:0] s);
    bit            has_out;
    logic [SW-1:0] res;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.sample_in <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_envelope(op, s, has_out, res);
    if (has_out) env_out_q.push_back(res);
    if (op != OP_NONE) sent_items++;
  endtask

  // Sender pause: drop valid and wait until every expected sample is out,
  // then give trailing key items time to finish.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (env_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // single register write; caller drains first
  task automatic write_reg(input reg_index_t idx, input logic [CFG_WIDTH-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_ATTACK_MS:  atk_ms    = val[MS_WIDTH-1:0];
      REG_DECAY_MS:   dec_ms    = val[MS_WIDTH-1:0];
      REG_RELEASE_MS: rel_ms    = val[MS_WIDTH-1:0];
      REG_SUSTAIN:    sus_level = val[LEVEL_WIDTH-1:0];
      REG_RATE_HZ:    rate_hz   = val[RATE_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic set_envelope(input int a, input int d, input int r, input int s,
                              input int hz);
    drain();
    write_reg(REG_RATE_HZ, CFG_WIDTH'(hz));
    write_reg(REG_ATTACK_MS, CFG_WIDTH'(a));
    write_reg(REG_DECAY_MS, CFG_WIDTH'(d));
    write_reg(REG_RELEASE_MS, CFG_WIDTH'(r));
    write_reg(REG_SUSTAIN, CFG_WIDTH'(s));
  endtask

  // full-range samples, with the corners pulled in now and then
  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return SW'($urandom());
    endcase
  endfunction

  // small durations so that each phase spans at most 60 samples
  task automatic randomize_envelope();
    int hz;
    int cap;
    int s;
    case ($urandom_range(5))
      0:       hz = 8000;
      1:       hz = 11025;
      2:       hz = 44100;
      3:       hz = 192000;
      default: hz = $urandom_range(192000, 8000);
    endcase
    cap = 60000 / hz;
    case ($urandom_range(9))
      0:       s = 0;
      1:       s = 32768;
      2:       s = $urandom_range(65535, 32769);   // above unity
      default: s = $urandom_range(32768, 0);
    endcase
    set_envelope($urandom_range(cap), $urandom_range(cap), $urandom_range(cap), s, hz);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, or a counted hold-off when requested
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output check: in order against the expected queue
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (env_out_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected sample_out, expected none, actual %0d", $time,
                   $signed(out_ch.sample_out));
      end else if (out_ch.sample_out !== env_out_q[0]) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time,
                   $signed(env_out_q[0]), $signed(out_ch.sample_out));
        void'(env_out_q.pop_front());
      end else begin
        void'(env_out_q.pop_front());
      end
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("adsr_envelope_gain_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: 14400-sample attack, so only the first steps are seen.
  // Also standby output, the unused opcode and an early key-up.
  task automatic test_reset_state();
    send_item(OP_SAMPLE, 16'h7FFF);      // standby -> 0
    send_item(OP_NONE, 16'h8000);        // ignored
    send_item(OP_KEY_DOWN, 16'h1234);
    send_item(OP_SAMPLE, 16'h8000);      // counter 0 -> zero gain
    send_item(OP_SAMPLE, 16'h7FFF);
    send_item(OP_KEY_UP, 16'h0000);      // release straight out of attack
    send_item(OP_SAMPLE, 16'hFFFF);
  endtask

  // One-sample attack and release, 8-sample decay at the lowest rate.
  // Walks the phase-ending samples that pass unscaled.
  task automatic test_short_envelope();
    set_envelope(0, 1, 0, 32768, 8000);
    send_item(OP_KEY_DOWN, 16'h0000);
    send_item(OP_SAMPLE, 16'h7FFF);      // attack, gain 0
    send_item(OP_SAMPLE, 16'h8000);      // attack done: passes unscaled
    send_item(OP_SAMPLE, 16'h8000);      // decay start, unity
    send_item(OP_SAMPLE, 16'd12345);
    send_item(OP_KEY_UP, 16'hFFFF);
    send_item(OP_SAMPLE, 16'd100);       // release shorter than 2: standby, 0
    send_item(OP_SAMPLE, 16'd100);
  endtask

  // Sustain above unity saturates both ways.
  task automatic test_sustain_above_unity();
    set_envelope(0, 0, 0, 65535, 8000);
    send_item(OP_KEY_DOWN, 16'h0000);
    send_item(OP_SAMPLE, 16'h0001);
    send_item(OP_SAMPLE, 16'h0001);      // to decay
    send_item(OP_SAMPLE, 16'h7FFF);
    send_item(OP_SAMPLE, 16'h7FFF);      // to sustain
    send_item(OP_SAMPLE, 16'h7FFF);      // clips high
    send_item(OP_SAMPLE, 16'h8000);      // clips low
    send_item(OP_SAMPLE, 16'd20000);
  endtask

  // Long 10000 ms durations at the 192000 Hz rate, zero sustain.
  task automatic test_config_extremes();
    set_envelope(10000, 10000, 10000, 0, 192000);
    send_item(OP_KEY_DOWN, 16'h0000);
    send_item(OP_SAMPLE, 16'h7FFF);
    send_item(OP_SAMPLE, 16'h8000);
    send_item(OP_KEY_UP, 16'h0000);
    send_item(OP_SAMPLE, 16'h8000);      // zero sustain -> zero release gain
    send_item(OP_SAMPLE, 16'h7FFF);
  endtask

  // Receiver holds off long enough that the block fills and stalls its input;
  // the sender keeps offering, then pauses until everything is out.
  task automatic test_output_holdoff();
    set_envelope(1, 1, 1, $urandom_range(32768), 11025);
    send_item(OP_KEY_DOWN, pick_sample());
    rx_hold = 400;
    repeat (24) send_item(OP_SAMPLE, pick_sample());
    drain();
  endtask

  // Mostly complete notes with random content, some mid-note register changes,
  // and a share of random noise items (including opcode 3).
  task automatic test_random_notes(input int count);
    int goal;
    int n;
    int cap;
    goal = sent_items + count;
    // start from short durations whatever the previous test left
    randomize_envelope();
    while (sent_items < goal) begin
      if ($urandom_range(3) == 0) randomize_envelope();
      if ($urandom_range(9) < 7) begin
        send_item(OP_KEY_DOWN, pick_sample());
        n = $urandom_range(32'((phase_span(atk_ms) + phase_span(dec_ms)) / 1000 + 8), 1);
        repeat (n / 2) send_item(OP_SAMPLE, pick_sample());
        if ($urandom_range(5) == 0) begin
          // change one register in the middle of a note
          drain();
          cap = 60000 / rate_hz;
          case ($urandom_range(4))
            0:       write_reg(REG_ATTACK_MS, CFG_WIDTH'($urandom_range(cap)));
            1:       write_reg(REG_DECAY_MS, CFG_WIDTH'($urandom_range(cap)));
            2:       write_reg(REG_RELEASE_MS, CFG_WIDTH'($urandom_range(cap)));
            3:       write_reg(REG_RATE_HZ, CFG_WIDTH'($urandom_range(12000, 8000)));
            default: write_reg(REG_SUSTAIN, CFG_WIDTH'($urandom_range(32768)));
          endcase
        end
        repeat (n - n / 2) send_item(OP_SAMPLE, pick_sample());
        send_item(OP_KEY_UP, pick_sample());
        n = $urandom_range(32'(phase_span(rel_ms) / 1000 + 3), 0);
        repeat (n) send_item(OP_SAMPLE, pick_sample());
      end else begin
        repeat ($urandom_range(12, 1))
          send_item(opcode_t'($urandom_range(3)), pick_sample());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_ATTACK_MS;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= OP_SAMPLE;
    in_ch.sample_in <= '0;

    gain_phase = ENV_STANDBY;
    gain_count = '0;
    atk_ms     = ATTACK_MS_RST;
    dec_ms     = DECAY_MS_RST;
    rel_ms     = RELEASE_MS_RST;
    sus_level  = SUSTAIN_RST;
    rate_hz    = RATE_RST;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // slow receiver first
    tx_idle_pct = 29;
    rx_idle_pct = 73;
    test_reset_state();
    test_short_envelope();
    test_sustain_above_unity();
    test_config_extremes();
    test_random_notes(500);

    // slow sender
    tx_idle_pct = 73;
    rx_idle_pct = 29;
    test_random_notes(500);

    // back to back
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_holdoff();
    test_random_notes(500);

    drain();
    repeat (END_CYCLES) @(posedge clk);

    if (errors == 0 && env_out_q.size() == 0) begin
      $display("adsr_envelope_gain_tb: done, clean");
    end else begin
      $display("adsr_envelope_gain_tb: done, errors");
    end
    $finish;
  end

endmodule
